FILE: rtl/pcs_pkg.sv
// Package: shared constants, types, microcode program and helper functions.
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

    localparam int MAX_BALLOTS_DEF = 1024;
    localparam int MAX_NOMINEES    = 32;
    localparam int SCORE_FRAC_BITS = 24;
    localparam int MASK_W          = 32;
    localparam int SUB_W           = MASK_W + 1;
    localparam int SCORE_W         = 37;
    localparam int CFG_W           = 6;
    localparam int POP_W           = 6;
    localparam int HARM_W          = SCORE_FRAC_BITS + 3;
    localparam int STEP_W          = 4;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;

    // register select is paddr[2]
    localparam logic REG_NOMINEE_COUNT = 1'b0;
    localparam logic REG_SEAT_COUNT    = 1'b1;

    localparam logic [CFG_W-1:0] NOMINEE_COUNT_RST = CFG_W'(32);
    localparam logic [CFG_W-1:0] SEAT_COUNT_RST    = CFG_W'(1);

    typedef logic [HARM_W-1:0] harm_arr_t [0:MAX_NOMINEES];

    // H(k) = H(k-1) + round(2^F / k), halves up
    function automatic harm_arr_t harm_build();
        harm_arr_t h;
        h[0] = '0;
        for (int i = 1; i <= MAX_NOMINEES; i++)
        begin
            h[i] = h[i-1] + HARM_W'(((64'd1 << SCORE_FRAC_BITS) + 64'(i / 2)) / 64'(i));
        end
        return h;
    endfunction

    localparam harm_arr_t HARM_TABLE = harm_build();

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT,
        OP_CLEAR,
        OP_SCORE,
        OP_COMPARE,
        OP_COUNT,
        OP_ADVANCE,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        CD_NEXT,
        CD_ALWAYS,
        CD_NOT_START,
        CD_SKIP,
        CD_BUSY,
        CD_MORE,
        CD_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic start;
        logic skip;
        logic busy;
        logic more;
        logic out_full;
    } dp_flags_t;

    localparam logic [STEP_W-1:0] ST_WAIT    = STEP_W'(0);
    localparam logic [STEP_W-1:0] ST_SETUP   = STEP_W'(1);
    localparam logic [STEP_W-1:0] ST_CLEAR   = STEP_W'(2);
    localparam logic [STEP_W-1:0] ST_SCORE   = STEP_W'(3);
    localparam logic [STEP_W-1:0] ST_COMPARE = STEP_W'(4);
    localparam logic [STEP_W-1:0] ST_COUNT   = STEP_W'(5);
    localparam logic [STEP_W-1:0] ST_ADVANCE = STEP_W'(6);
    localparam logic [STEP_W-1:0] ST_TEST    = STEP_W'(7);
    localparam logic [STEP_W-1:0] ST_EMIT    = STEP_W'(8);
    localparam logic [STEP_W-1:0] ST_RETURN  = STEP_W'(9);

    // control store
    function automatic uword_t ucode_word(input logic [STEP_W-1:0] addr);
        uword_t w;
        w = '{op: OP_NOP, cond: CD_ALWAYS, target: ST_WAIT};
        case (addr)
            ST_WAIT:    w = '{op: OP_LOAD,    cond: CD_NOT_START, target: ST_WAIT};
            ST_SETUP:   w = '{op: OP_INIT,    cond: CD_SKIP,      target: ST_EMIT};
            ST_CLEAR:   w = '{op: OP_CLEAR,   cond: CD_NEXT,      target: ST_WAIT};
            ST_SCORE:   w = '{op: OP_SCORE,   cond: CD_BUSY,      target: ST_SCORE};
            ST_COMPARE: w = '{op: OP_COMPARE, cond: CD_NEXT,      target: ST_WAIT};
            ST_COUNT:   w = '{op: OP_COUNT,   cond: CD_NEXT,      target: ST_WAIT};
            ST_ADVANCE: w = '{op: OP_ADVANCE, cond: CD_NEXT,      target: ST_WAIT};
            ST_TEST:    w = '{op: OP_NOP,     cond: CD_MORE,      target: ST_CLEAR};
            ST_EMIT:    w = '{op: OP_EMIT,    cond: CD_OUT_FULL,  target: ST_EMIT};
            ST_RETURN:  w = '{op: OP_NOP,     cond: CD_ALWAYS,    target: ST_WAIT};
            default:    ;
        endcase
        return w;
    endfunction

    function automatic logic [POP_W-1:0] pop8(input logic [7:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [POP_W-1:0] pop32(input logic [MASK_W-1:0] v);
        return pop8(v[7:0]) + pop8(v[15:8]) + pop8(v[23:16]) + pop8(v[31:24]);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pav_committee_search_unit.sv
// Top level: APB register file, microcode sequencer and search datapath.
// Ballot words are taken one per cycle until the word marked last.
// After the last word: a setup step, then each of the C(n, k) committees is scored over
// the B stored ballots (none if the setup is skipped); the result register loads at emit.
// Run time is set by the single ballot memory read port, one ballot per cycle.
// Reset clears the sequencer, ballot count and result valid; ballot memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module pav_committee_search_unit
    import pcs_pkg::*;
#(
    parameter int MAX_BALLOTS = MAX_BALLOTS_DEF
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [APB_AW-1:0]  paddr,
    input  wire  [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire  [MASK_W-1:0]  ballot_mask,
    input  wire                last_ballot,
    output logic               out_valid,
    input  wire                out_stall,
    output logic [MASK_W-1:0]  winner_mask,
    output logic [SCORE_W-1:0] winner_score,
    output logic               invalid_setup
);

    logic [CFG_W-1:0] nominee_count_reg;
    logic [CFG_W-1:0] seat_count_reg;
    logic             cfg_wr;
    op_t              op;
    dp_flags_t        flags;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominee_count_reg <= NOMINEE_COUNT_RST;
            seat_count_reg    <= SEAT_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_NOMINEE_COUNT)
            begin
                nominee_count_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                seat_count_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_NOMINEE_COUNT: prdata = APB_DW'(nominee_count_reg);
            REG_SEAT_COUNT:    prdata = APB_DW'(seat_count_reg);
            default:           prdata = '0;
        endcase
    end

    pcs_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op)
    );

    pcs_datapath #(
        .MAX_BALLOTS (MAX_BALLOTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .nominee_count (nominee_count_reg),
        .seat_count    (seat_count_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .ballot_mask   (ballot_mask),
        .last_ballot   (last_ballot),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .winner_mask   (winner_mask),
        .winner_score  (winner_score),
        .invalid_setup (invalid_setup),
        .flags         (flags)
    );

endmodule

`default_nettype wire

FILE: rtl/pcs_sequencer.sv
// Microcode sequencer: step counter, control store read and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module pcs_sequencer
    import pcs_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  dp_flags_t  flags,
    output op_t        op
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    uword_t            word;
    logic              take;

    assign word = ucode_word(step_reg);
    assign op   = word.op;

    always_comb
    begin
        unique case (word.cond)
            CD_NEXT:      take = 1'b0;
            CD_ALWAYS:    take = 1'b1;
            CD_NOT_START: take = !flags.start;
            CD_SKIP:      take = flags.skip;
            CD_BUSY:      take = flags.busy;
            CD_MORE:      take = flags.more;
            CD_OUT_FULL:  take = flags.out_full;
            default:      take = 1'b0;
        endcase
        step_next = take ? word.target : step_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pcs_datapath.sv
// Datapath: ballot memory, scoring pipeline, subset stepping and result register.
`timescale 1ns / 1ps
`default_nettype none

module pcs_datapath
    import pcs_pkg::*;
#(
    parameter int MAX_BALLOTS = MAX_BALLOTS_DEF
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  op_t                op,
    input  wire  [CFG_W-1:0]   nominee_count,
    input  wire  [CFG_W-1:0]   seat_count,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire  [MASK_W-1:0]  ballot_mask,
    input  wire                last_ballot,
    output logic               out_valid,
    input  wire                out_stall,
    output logic [MASK_W-1:0]  winner_mask,
    output logic [SCORE_W-1:0] winner_score,
    output logic               invalid_setup,
    output dp_flags_t          flags
);

    localparam int CNT_W = $clog2(MAX_BALLOTS + 1);
    localparam int AW    = (MAX_BALLOTS > 1) ? $clog2(MAX_BALLOTS) : 1;

    logic [MASK_W-1:0]  ballot_mem [0:MAX_BALLOTS-1];
    logic [MASK_W-1:0]  rd_data_reg;

    logic [CNT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic               va_reg, vb_reg;
    logic               out_valid_reg, out_valid_next;

    logic [CFG_W-1:0]   n_reg, k_reg;
    logic               invalid_reg;
    logic [SUB_W-1:0]   cur_reg, ripple_reg;
    logic [MASK_W-1:0]  best_subset_reg;
    logic [SCORE_W-1:0] best_total_reg, running_reg;
    logic [POP_W-1:0]   pc_reg;
    logic [MASK_W-1:0]  win_mask_reg;
    logic [SCORE_W-1:0] win_score_reg;
    logic               win_invalid_reg;

    logic               in_take, store_ok, issue, out_full, emit_go;
    logic [CFG_W-1:0]   n_sat;
    logic               invalid_c, skip_c;
    logic [SUB_W-1:0]   first_c, limit, fill;
    logic [CFG_W-1:0]   fill_len;
    logic [MASK_W-1:0]  pop_in;
    logic [SCORE_W:0]   sum;

    assign in_stall = (op != OP_LOAD);
    assign in_take  = in_valid && (op == OP_LOAD);
    assign store_ok = total_reg < CNT_W'(MAX_BALLOTS);
    assign issue    = (op == OP_SCORE) && (rd_cnt_reg < total_reg);
    assign out_full = out_valid_reg && out_stall;
    assign emit_go  = (op == OP_EMIT) && !out_full;

    assign n_sat     = (nominee_count > CFG_W'(MAX_NOMINEES)) ? CFG_W'(MAX_NOMINEES)
                                                               : nominee_count;
    assign invalid_c = seat_count > n_sat;
    assign skip_c    = invalid_c || (seat_count == '0);
    assign first_c   = (SUB_W'(1) << seat_count) - SUB_W'(1);
    assign limit     = SUB_W'(1) << n_reg;

    // refill length after the carry: seats minus ones left in the ripple word
    assign fill_len  = k_reg - pc_reg;
    assign fill      = (SUB_W'(1) << fill_len) - SUB_W'(1);

    assign pop_in    = (op == OP_COUNT) ? ripple_reg[MASK_W-1:0]
                                        : (rd_data_reg & cur_reg[MASK_W-1:0]);
    assign sum       = {1'b0, running_reg} + (SCORE_W + 1)'(HARM_TABLE[pc_reg]);

    assign flags = '{
        start:    in_take && last_ballot,
        skip:     skip_c,
        busy:     (rd_cnt_reg < total_reg) || va_reg || vb_reg,
        more:     cur_reg < limit,
        out_full: out_full
    };

    assign out_valid     = out_valid_reg;
    assign winner_mask   = win_mask_reg;
    assign winner_score  = win_score_reg;
    assign invalid_setup = win_invalid_reg;

    always_comb
    begin
        total_next = total_reg;
        if (emit_go)
        begin
            total_next = '0;
        end
        else if (in_take && store_ok)
        begin
            total_next = total_reg + CNT_W'(1);
        end

        rd_cnt_next = rd_cnt_reg;
        if (op == OP_CLEAR)
        begin
            rd_cnt_next = '0;
        end
        else if (issue)
        begin
            rd_cnt_next = rd_cnt_reg + CNT_W'(1);
        end

        out_valid_next = out_valid_reg;
        if (emit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            rd_cnt_reg    <= '0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            rd_cnt_reg    <= rd_cnt_next;
            va_reg        <= issue;
            vb_reg        <= va_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && store_ok)
        begin
            ballot_mem[total_reg[AW-1:0]] <= ballot_mask;
        end
        rd_data_reg <= ballot_mem[rd_cnt_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        pc_reg <= pop32(pop_in);

        if (op == OP_CLEAR)
        begin
            running_reg <= '0;
        end
        else if (vb_reg)
        begin
            running_reg <= sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
        end

        case (op)
            OP_INIT:
            begin
                n_reg           <= n_sat;
                k_reg           <= seat_count;
                invalid_reg     <= invalid_c;
                cur_reg         <= first_c;
                best_subset_reg <= skip_c ? '0 : first_c[MASK_W-1:0];
                best_total_reg  <= '0;
            end
            OP_COMPARE:
            begin
                if (running_reg > best_total_reg)
                begin
                    best_total_reg  <= running_reg;
                    best_subset_reg <= cur_reg[MASK_W-1:0];
                end
                ripple_reg <= cur_reg + (cur_reg & (~cur_reg + SUB_W'(1)));
            end
            OP_ADVANCE:
            begin
                cur_reg <= ripple_reg | fill;
            end
            default:
            begin
            end
        endcase

        if (emit_go)
        begin
            win_mask_reg    <= best_subset_reg;
            win_score_reg   <= best_total_reg;
            win_invalid_reg <= invalid_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pcs_checker.sv
// Port-level checker for the committee search unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pcs_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_stall,
    input wire        last_ballot,
    input wire        out_valid,
    input wire        out_stall,
    input wire [31:0] winner_mask,
    input wire [36:0] winner_score,
    input wire        invalid_setup
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(winner_mask)
            && $stable(winner_score) && $stable(invalid_setup))
        else $error("result word changed while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid_setup |-> winner_mask == '0 && winner_score == '0)
        else $error("invalid setup with nonzero result");

    // search runs right after the last ballot, so no ballot is taken next cycle
    a_search_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_ballot |=> in_stall)
        else $error("ballot input open right after last ballot");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind pav_committee_search_unit pcs_checker u_pcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .last_ballot   (last_ballot),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .winner_mask   (winner_mask),
    .winner_score  (winner_score),
    .invalid_setup (invalid_setup)
);

`default_nettype wire

FILE: dv/tb_pav_committee_search_unit.sv
// Testbench for the committee search unit: ballot driver, result checker and search predictor.
`timescale 1ns / 1ps

module tb_pav_committee_search_unit;
    import pcs_pkg::*;

    localparam int STORE_DEPTH   = MAX_BALLOTS_DEF;
    localparam int RANDOM_ITEMS  = 850;
    localparam int MIN_ELECTIONS = 40;
    localparam int SEARCH_BUDGET = 20000;  // rough cycles per election
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 3000;
    localparam logic [SCORE_W-1:0] SCORE_SAT = '1;

    typedef struct {
        logic [MASK_W-1:0] mask;
        logic              last;
    } ballot_word_t;

    typedef struct {
        logic [MASK_W-1:0]  mask;
        logic [SCORE_W-1:0] score;
        logic               invalid;
    } committee_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b1;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [MASK_W-1:0]   ballot_mask = '0;
    logic                last_ballot = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [MASK_W-1:0]   winner_mask;
    logic [SCORE_W-1:0]  winner_score;
    logic                invalid_setup;

    pav_committee_search_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .ballot_mask   (ballot_mask),
        .last_ballot   (last_ballot),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .winner_mask   (winner_mask),
        .winner_score  (winner_score),
        .invalid_setup (invalid_setup)
    );

    always #4 clk = ~clk;

    ballot_word_t       pending_ballots[$];
    committee_t         due_winners[$];
    logic [MASK_W-1:0]  tally_store [STORE_DEPTH];
    int unsigned        tally_count = 0;
    logic [CFG_W-1:0]   cfg_nominees = 6'd32;
    logic [CFG_W-1:0]   cfg_seats = 6'd1;
    logic [SCORE_W-1:0] harmonic [0:MAX_NOMINEES];

    int          mismatches = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_request = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    logic        in_took = 1'b0;
    logic        in_random = 1'b0;
    int unsigned random_items = 0;
    int unsigned elections_done = 0;

    function automatic longint unsigned committee_count(int unsigned n, int unsigned k);
        longint unsigned c;
        c = 1;
        for (int unsigned i = 0; i < k; i++)
        begin
            c = c * 64'(n - i) / 64'(i + 1);
        end
        return c;
    endfunction

    // exhaustive search over all k-subsets of the low n nominees, first best wins
    function automatic committee_t elect_committee();
        committee_t  r;
        int unsigned n, k;
        logic [63:0] subset, limit, low, ripple, total, best;
        logic [MASK_W-1:0] best_set;
        n = (cfg_nominees > 6'd32) ? 32 : 32'(cfg_nominees);
        k = 32'(cfg_seats);
        r.mask = '0;
        r.score = '0;
        r.invalid = 1'b0;
        if (k > n)
            r.invalid = 1'b1;
        else if (k != 0)
        begin
            limit = 64'd1 << n;
            subset = (64'd1 << k) - 64'd1;
            best_set = subset[MASK_W-1:0];
            best = '0;
            while (subset < limit)
            begin
                total = '0;
                for (int unsigned b = 0; b < tally_count; b++)
                begin
                    total = total
                        + 64'(harmonic[$countones(tally_store[b] & subset[MASK_W-1:0])]);
                    if (total > 64'(SCORE_SAT))
                        total = 64'(SCORE_SAT);
                end
                if (total > best)
                begin
                    best = total;
                    best_set = subset[MASK_W-1:0];
                end
                // next subset with the same popcount
                low = subset & (~subset + 64'd1);
                ripple = subset + low;
                subset = (((ripple ^ subset) >> 2) / low) | ripple;
            end
            r.mask = best_set;
            r.score = best[SCORE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [MASK_W-1:0] random_ballot();
        logic [MASK_W-1:0] low;
        low = (cfg_nominees >= 6'd32) ? '1 : ((MASK_W'(1) << cfg_nominees) - MASK_W'(1));
        case ($urandom_range(9))
            0, 1, 2: return $urandom();
            3, 4:    return $urandom() & $urandom();
            5:       return $urandom() | $urandom();
            6, 7:    return $urandom() & low;
            8:       return $urandom() & $urandom() & low;
            default:
            begin
                case ($urandom_range(2))
                    0:       return '0;
                    1:       return '1;
                    default: return MASK_W'(1) << $urandom_range(31);
                endcase
            end
        endcase
    endfunction

    // input side: store accepted words, predict on the last one
    always @(posedge clk)
    begin
        in_took <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            if (tally_count < STORE_DEPTH)
            begin
                tally_store[tally_count] = ballot_mask;
                tally_count++;
            end
            if (last_ballot)
            begin
                due_winners.push_back(elect_committee());
                tally_count = 0;
            end
        end
    end

    always @(posedge clk)
    begin
        committee_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_winners.size() == 0)
            begin
                $error("result word with none due: winner_mask %h", winner_mask);
                mismatches++;
            end
            else
            begin
                want = due_winners.pop_front();
                if (winner_mask !== want.mask)
                begin
                    $error("winner_mask: expected %h, got %h", want.mask, winner_mask);
                    mismatches++;
                end
                if (winner_score !== want.score)
                begin
                    $error("winner_score: expected %h, got %h", want.score, winner_score);
                    mismatches++;
                end
                if (invalid_setup !== want.invalid)
                begin
                    $error("invalid_setup: expected %b, got %b", want.invalid, invalid_setup);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        ballot_word_t w;
        if (!in_valid || in_took)
        begin
            if (rst_n && pending_ballots.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                w = pending_ballots.pop_front();
                in_valid <= 1'b1;
                ballot_mask <= w.mask;
                last_ballot <= w.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_request)
        begin
            hold_seen <= hold_request;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic apb_write(input logic sel, input logic [CFG_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= ($urandom() & ~APB_DW'(63)) | APB_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_ballots.size() != 0 || in_valid || due_winners.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // returns at a rising edge so that words are queued away from the driver
    task automatic configure(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] k);
        wait_idle();
        apb_write(REG_NOMINEE_COUNT, n);
        apb_write(REG_SEAT_COUNT, k);
        cfg_nominees = n;
        cfg_seats = k;
        @(posedge clk);
    endtask

    task automatic cast_ballot(input logic [MASK_W-1:0] mask, input logic last);
        pending_ballots.push_back('{mask: mask, last: last});
        if (in_random)
            random_items++;
        if (last)
            elections_done++;
    endtask

    task automatic queue_election(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            cast_ballot(random_ballot(), i == count - 1);
    endtask

    initial
    begin
        logic [CFG_W-1:0] n, k;
        int unsigned      n_eff, pick, max_b, phase, blocks;
        longint unsigned  cost;

        rst_n <= 1'b0;
        harmonic[0] = '0;
        for (int j = 1; j <= MAX_NOMINEES; j++)
            harmonic[j] = harmonic[j-1]
                + ((SCORE_W'(1) << SCORE_FRAC_BITS) + SCORE_W'(j / 2)) / SCORE_W'(j);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: 32 nominees, one seat
        cast_ballot(32'hFFFF_FFFF, 1'b0);
        cast_ballot(32'h8000_0000, 1'b0);
        cast_ballot(32'h8000_0000, 1'b1);
        // all committees tie, earliest kept
        configure(6'd4, 6'd2);
        cast_ballot(32'h0000_000F, 1'b1);
        // zero nominees
        configure(6'd0, 6'd1);
        cast_ballot(32'h0000_0000, 1'b1);
        // more seats than nominees
        configure(6'd5, 6'd6);
        cast_ballot($urandom(), 1'b0);
        cast_ballot($urandom(), 1'b1);
        // no seats
        configure(6'd8, 6'd0);
        cast_ballot(32'h0000_00FF, 1'b0);
        cast_ballot(32'hFFFF_FFFF, 1'b1);
        // nominee count saturates
        configure(6'd63, 6'd2);
        cast_ballot(32'hC000_0000, 1'b0);
        cast_ballot(32'h0000_0003, 1'b0);
        cast_ballot(32'hC000_0000, 1'b1);
        configure(6'd32, 6'd32);
        cast_ballot(32'hFFFF_FFFF, 1'b0);
        cast_ballot(32'h5555_5555, 1'b1);
        configure(6'd1, 6'd1);
        cast_ballot(32'h0000_0001, 1'b0);
        cast_ballot(32'hFFFF_FFFE, 1'b1);
        configure(6'd32, 6'd63);
        cast_ballot(32'hFFFF_FFFF, 1'b1);
        configure(6'd7, 6'd3);
        cast_ballot(32'h0000_0000, 1'b0);
        cast_ballot(32'h0000_007F, 1'b0);
        cast_ballot(32'h0000_0046, 1'b0);
        cast_ballot(32'hAAAA_AA19, 1'b1);

        in_random = 1'b1;
        elections_done = 0;
        blocks = 0;
        while (random_items < RANDOM_ITEMS || elections_done < MIN_ELECTIONS)
        begin
            phase = random_items * 4 / RANDOM_ITEMS;
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 79; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 79; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase
            blocks++;
            if (blocks == 6)
            begin
                // receiver holds off while several elections queue up behind it
                configure(6'd5, 6'd2);
                hold_request++;
                repeat (4) queue_election($urandom_range(8, 16));
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    n = CFG_W'($urandom_range(1, 10));
                    k = CFG_W'($urandom_range(1, n));
                end
                else if (pick < 70)
                begin
                    n = CFG_W'($urandom_range(11, 20));
                    case ($urandom_range(5))
                        0:       k = 6'd1;
                        1:       k = 6'd2;
                        2:       k = 6'd3;
                        3:       k = n - 6'd2;
                        4:       k = n - 6'd1;
                        default: k = n;
                    endcase
                end
                else if (pick < 80)
                begin
                    n = CFG_W'($urandom_range(32, 63));
                    case ($urandom_range(4))
                        0:       k = 6'd1;
                        1:       k = 6'd2;
                        2:       k = 6'd30;
                        3:       k = 6'd31;
                        default: k = 6'd32;
                    endcase
                end
                else if (pick < 90)
                begin
                    n = CFG_W'($urandom_range(0, 31));
                    k = CFG_W'($urandom_range(n + 1, 63));
                end
                else
                begin
                    n = CFG_W'($urandom_range(0, 63));
                    k = '0;
                end
                configure(n, k);
                n_eff = (n > 6'd32) ? 32 : 32'(n);
                cost = (32'(k) > n_eff || k == '0) ? 64'd1 : committee_count(n_eff, 32'(k));
                max_b = (SEARCH_BUDGET / cost > 68) ? 60
                      : ((SEARCH_BUDGET / cost > 9) ? 32'(SEARCH_BUDGET / cost) - 8 : 1);
                repeat ($urandom_range(1, 4))
                    queue_election(($urandom_range(9) < 7)
                        ? $urandom_range(1, (max_b < 16) ? max_b : 16)
                        : $urandom_range(1, max_b));
            end
        end
        in_random = 1'b0;

        wait_idle();
        repeat (50) @(negedge clk);
        if (mismatches == 0 && due_winners.size() == 0)
            $display("tb_pav_committee_search_unit: PASS");
        else
            $display("tb_pav_committee_search_unit: FAIL");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("tb_pav_committee_search_unit: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pcs_pkg.sv
rtl/pcs_sequencer.sv
rtl/pcs_datapath.sv
rtl/pav_committee_search_unit.sv
rtl/pcs_checker.sv
dv/tb_pav_committee_search_unit.sv
